@@ sv/gbn_snd_pkg.sv @@
// ----------------------------------------------------------------------------
// gbn_snd_pkg : shared types and constants of the go-back-N sender window
// Widths, window geometry, sequencer states and result codes.
// ----------------------------------------------------------------------------
package gbn_snd_pkg;

  // Window geometry and frame size (frame size is a power of two).
  localparam int WINDOW_SLOTS  = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int PAYLOAD_LOG2  = 10;
  localparam int PAYLOAD_BYTES = 1 << PAYLOAD_LOG2;
  localparam int SCAN_LIMIT    = (WINDOW_SLOTS < MAX_RESULTS) ? WINDOW_SLOTS : MAX_RESULTS;

  localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int SCAN_W = $clog2(SCAN_LIMIT + 1);

  // Field widths.
  localparam int FRAME_W   = 32;
  localparam int ATTEMPT_W = 8;
  localparam int TIME_W    = 32;
  localparam int RTT_W     = 16;
  localparam int LEN_W     = 16;
  localparam int WSIZE_W   = 5;
  localparam int TOTAL_W   = 40;
  localparam int FIN_W     = TOTAL_W - PAYLOAD_LOG2;

  // Stream packing.
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 80;
  localparam int CFG_IDX_W  = 2;

  // Divide-by-five unit: two quotient bits per step.
  localparam int DIV_W     = TIME_W + 2;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_RTT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BYTES = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACK,
    ST_DIV,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef enum logic {
    FUNC_ACK  = 1'b0,
    FUNC_SCAN = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    KIND_ACK_OK  = 2'd0,
    KIND_ACK_REJ = 2'd1,
    KIND_SEND    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [FRAME_W-1:0]   frame;
    logic [ATTEMPT_W-1:0] attempt;
    logic [LEN_W-1:0]     len;
    logic                 fin;
  } result_t;

endpackage

@@ sv/go_back_n_sender_window.sv @@
// ----------------------------------------------------------------------------
// go_back_n_sender_window : go-back-N sender window controller
// Retires window slots on acks, refreshes the rtt estimate and issues send
// commands for slots that are new or timed out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat is an event. tuser selects ack (0) or timer scan (1);
//           tdata carries ack frame, ack attempt and the current time in ms.
//   out_* : result beats. tuser is the result kind, tlast marks the final
//           beat caused by one event.
//   cfg_* : register writes (window size, initial rtt, total bytes), always
//           taken; write only while the block is idle.
// Timing: one event at a time. An ack that refreshes the rtt passes through
//   the divide-by-five unit, which retires two quotient bits a cycle. A scan
//   visits window slots up to window_size (clamped to 1..SCAN_LIMIT) and
//   stalls while a send beat has to wait for the receiver.
// Reset clears the window, the frame counters and the completion flag, and
//   loads the default registers (rtt estimate = 100 ms).
// Receiver stall: the output register holds its beat; the scan stops on a
//   second due slot until the held beat is taken.
// ----------------------------------------------------------------------------
module go_back_n_sender_window (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // tdata: ack_frame[31:0], ack_attempt[39:32], now_ms[71:40]
  input  logic [gbn_snd_pkg::IN_DATA_W-1:0]     in_tdata,
  // tuser: func
  input  logic                                  in_tuser,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // tdata: frame_number[31:0], attempt[39:32], payload_length[55:40],
  //        final_frame[56], all_acked[57], rtt_ms[73:58], zero[79:74]
  output logic [gbn_snd_pkg::OUT_DATA_W-1:0]    out_tdata,
  // tuser: kind
  output logic [1:0]                            out_tuser,
  output logic                                  out_tlast,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [gbn_snd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gbn_snd_pkg::TOTAL_W-1:0]       cfg_data
);

  localparam int FRAME_W   = gbn_snd_pkg::FRAME_W;
  localparam int ATTEMPT_W = gbn_snd_pkg::ATTEMPT_W;
  localparam int TIME_W    = gbn_snd_pkg::TIME_W;
  localparam int RTT_W     = gbn_snd_pkg::RTT_W;
  localparam int LEN_W     = gbn_snd_pkg::LEN_W;
  localparam int SLOTS     = gbn_snd_pkg::WINDOW_SLOTS;
  localparam int SLOT_W    = gbn_snd_pkg::SLOT_W;
  localparam int SCAN_W    = gbn_snd_pkg::SCAN_W;
  localparam int FIN_W     = gbn_snd_pkg::FIN_W;
  localparam int TOTAL_W   = gbn_snd_pkg::TOTAL_W;
  localparam int DIV_W     = gbn_snd_pkg::DIV_W;
  localparam int DIV_CNT_W = gbn_snd_pkg::DIV_CNT_W;
  localparam int P_LOG2    = gbn_snd_pkg::PAYLOAD_LOG2;

  // Configuration registers.
  logic [gbn_snd_pkg::WSIZE_W-1:0] wsize_r, wsize_nxt;
  logic [RTT_W-1:0]                init_rtt_r, init_rtt_nxt;
  logic [TOTAL_W-1:0]              total_r, total_nxt;

  // Sender state.
  gbn_snd_pkg::state_t   state_r, state_nxt;
  logic [FRAME_W-1:0]    nae_r, nae_nxt;          // next ack expected
  logic [RTT_W-1:0]      rtt_r, rtt_nxt;
  logic                  final_acked_r, final_acked_nxt;
  logic [TIME_W-1:0]     slot_time_r [SLOTS];
  logic [TIME_W-1:0]     slot_time_nxt [SLOTS];
  logic [ATTEMPT_W-1:0]  slot_cnt_r [SLOTS];
  logic [ATTEMPT_W-1:0]  slot_cnt_nxt [SLOTS];
  logic [SLOTS-1:0]      slot_sent_r, slot_sent_nxt;

  // Latched event.
  logic                  ev_func_r, ev_func_nxt;
  logic [FRAME_W-1:0]    ev_frame_r, ev_frame_nxt;
  logic [ATTEMPT_W-1:0]  ev_att_r, ev_att_nxt;
  logic [TIME_W-1:0]     ev_now_r, ev_now_nxt;

  // Sequencer working registers.
  logic [SCAN_W-1:0]     idx_r, idx_nxt;
  gbn_snd_pkg::result_t  pend_r, pend_nxt;
  logic                  pend_valid_r, pend_valid_nxt;
  logic [DIV_W-1:0]      div_q_r, div_q_nxt;
  logic [2:0]            div_rem_r, div_rem_nxt;
  logic [DIV_CNT_W-1:0]  div_cnt_r, div_cnt_nxt;

  // Output register.
  gbn_snd_pkg::result_t  out_res_r, out_res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_all_r, out_all_nxt;
  logic [RTT_W-1:0]      out_rtt_r, out_rtt_nxt;

  // Frame layout derived from total_bytes.
  logic [FIN_W-1:0]      fin_idx;
  logic [FRAME_W-1:0]    fin_frame;
  logic [TOTAL_W-1:0]    tail_bytes;
  logic [LEN_W-1:0]      last_len;
  logic [TOTAL_W-1:0]    total_m1;

  // Scan and ack datapath.
  logic [SCAN_W-1:0]     ws_eff;
  logic [SLOT_W-1:0]     sidx;
  logic [FRAME_W-1:0]    scan_frame;
  logic [TIME_W-1:0]     scan_age;
  logic                  scan_end;
  logic                  scan_due;
  logic                  out_free;
  logic                  ack_reject;
  logic                  ack_fin;
  logic                  rtt_refresh;
  logic [TIME_W-1:0]     meas;

  // Divide-by-five step: two quotient bits.
  logic [3:0]            dv_t1, dv_t2;
  logic                  dv_ge1, dv_ge2;
  logic [2:0]            dv_r1, dv_r2;
  logic [DIV_W-1:0]      dv_q1, dv_q2;

  function automatic logic [LEN_W-1:0] frame_len(input logic [FRAME_W-1:0] f,
                                                 input logic [FRAME_W-1:0] fin,
                                                 input logic [LEN_W-1:0]   tail);
    logic [LEN_W-1:0] len;
    if (f < fin) begin
      len = LEN_W'(gbn_snd_pkg::PAYLOAD_BYTES);
    end else if (f == fin) begin
      len = tail;
    end else begin
      len = '0;
    end
    return len;
  endfunction

  assign total_m1   = total_r - TOTAL_W'(1);
  assign fin_idx    = (total_r == '0) ? '0 : total_m1[TOTAL_W-1:P_LOG2];
  assign fin_frame  = FRAME_W'(fin_idx);
  assign tail_bytes = total_r - (TOTAL_W'(fin_idx) << P_LOG2);
  assign last_len   = tail_bytes[LEN_W-1:0];

  // Clamp window size to 1..SCAN_LIMIT.
  always_comb begin
    if (wsize_r == '0) begin
      ws_eff = SCAN_W'(1);
    end else if (32'(wsize_r) > gbn_snd_pkg::SCAN_LIMIT) begin
      ws_eff = SCAN_W'(gbn_snd_pkg::SCAN_LIMIT);
    end else begin
      ws_eff = SCAN_W'(wsize_r);
    end
  end

  assign sidx       = idx_r[SLOT_W-1:0];
  assign scan_frame = nae_r + FRAME_W'(idx_r);
  assign scan_age   = ev_now_r - slot_time_r[sidx];
  assign scan_end   = (idx_r >= ws_eff) || final_acked_r || (scan_frame > fin_frame);
  assign scan_due   = !slot_sent_r[sidx] ||
                      (scan_age > TIME_W'({rtt_r, 1'b0}));

  assign ack_reject  = final_acked_r || (ev_frame_r != nae_r) || !slot_sent_r[0];
  assign ack_fin     = (ev_frame_r == fin_frame);
  assign rtt_refresh = (ev_att_r == (slot_cnt_r[0] - ATTEMPT_W'(1)));
  assign meas        = ev_now_r - slot_time_r[0];

  assign out_free = !out_valid_r || out_tready;

  assign dv_t1  = {div_rem_r, div_q_r[DIV_W-1]};
  assign dv_ge1 = (dv_t1 >= 4'd5);
  assign dv_r1  = dv_ge1 ? 3'(dv_t1 - 4'd5) : dv_t1[2:0];
  assign dv_q1  = {div_q_r[DIV_W-2:0], dv_ge1};
  assign dv_t2  = {dv_r1, dv_q1[DIV_W-1]};
  assign dv_ge2 = (dv_t2 >= 4'd5);
  assign dv_r2  = dv_ge2 ? 3'(dv_t2 - 4'd5) : dv_t2[2:0];
  assign dv_q2  = {dv_q1[DIV_W-2:0], dv_ge2};

  // Next state and datapath.
  always_comb begin
    logic                 push;
    logic                 push_last;
    gbn_snd_pkg::result_t push_res;

    state_nxt       = state_r;
    wsize_nxt       = wsize_r;
    init_rtt_nxt    = init_rtt_r;
    total_nxt       = total_r;
    nae_nxt         = nae_r;
    rtt_nxt         = rtt_r;
    final_acked_nxt = final_acked_r;
    slot_time_nxt   = slot_time_r;
    slot_cnt_nxt    = slot_cnt_r;
    slot_sent_nxt   = slot_sent_r;
    ev_func_nxt     = ev_func_r;
    ev_frame_nxt    = ev_frame_r;
    ev_att_nxt      = ev_att_r;
    ev_now_nxt      = ev_now_r;
    idx_nxt         = idx_r;
    pend_nxt        = pend_r;
    pend_valid_nxt  = pend_valid_r;
    div_q_nxt       = div_q_r;
    div_rem_nxt     = div_rem_r;
    div_cnt_nxt     = div_cnt_r;
    push            = 1'b0;
    push_last       = 1'b0;
    push_res        = pend_r;

    case (state_r)
      gbn_snd_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          ev_func_nxt    = in_tuser;
          ev_frame_nxt   = in_tdata[31:0];
          ev_att_nxt     = in_tdata[39:32];
          ev_now_nxt     = in_tdata[71:40];
          idx_nxt        = '0;
          pend_valid_nxt = 1'b0;
          state_nxt      = (gbn_snd_pkg::func_t'(in_tuser) == gbn_snd_pkg::FUNC_SCAN) ?
                           gbn_snd_pkg::ST_SCAN : gbn_snd_pkg::ST_ACK;
        end
      end

      gbn_snd_pkg::ST_ACK: begin
        pend_valid_nxt   = 1'b1;
        pend_nxt.frame   = ev_frame_r;
        pend_nxt.attempt = ev_att_r;
        if (ack_reject) begin
          pend_nxt.kind = gbn_snd_pkg::KIND_ACK_REJ;
          pend_nxt.len  = '0;
          pend_nxt.fin  = 1'b0;
          state_nxt     = gbn_snd_pkg::ST_FLUSH;
        end else begin
          pend_nxt.kind = gbn_snd_pkg::KIND_ACK_OK;
          pend_nxt.len  = frame_len(ev_frame_r, fin_frame, last_len);
          pend_nxt.fin  = ack_fin;
          // Retire the oldest slot and slide the window.
          for (int i = 0; i < SLOTS - 1; i++) begin
            slot_time_nxt[i] = slot_time_r[i+1];
            slot_cnt_nxt[i]  = slot_cnt_r[i+1];
            slot_sent_nxt[i] = slot_sent_r[i+1];
          end
          slot_time_nxt[SLOTS-1] = '0;
          slot_cnt_nxt[SLOTS-1]  = '0;
          slot_sent_nxt[SLOTS-1] = 1'b0;
          nae_nxt = nae_r + FRAME_W'(1);
          if (ack_fin) begin
            final_acked_nxt = 1'b1;
          end
          if (rtt_refresh) begin
            div_q_nxt   = DIV_W'(meas) + DIV_W'({rtt_r, 2'b00});
            div_rem_nxt = '0;
            div_cnt_nxt = '0;
            state_nxt   = gbn_snd_pkg::ST_DIV;
          end else begin
            state_nxt = gbn_snd_pkg::ST_FLUSH;
          end
        end
      end

      gbn_snd_pkg::ST_DIV: begin
        div_q_nxt   = dv_q2;
        div_rem_nxt = dv_r2;
        div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
        if (div_cnt_r == DIV_CNT_W'(gbn_snd_pkg::DIV_STEPS - 1)) begin
          // Saturate the new estimate to 16 bits.
          rtt_nxt   = (|dv_q2[DIV_W-1:RTT_W]) ? '1 : dv_q2[RTT_W-1:0];
          state_nxt = gbn_snd_pkg::ST_FLUSH;
        end
      end

      gbn_snd_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_nxt = gbn_snd_pkg::ST_FLUSH;
        end else if (!scan_due) begin
          idx_nxt = idx_r + SCAN_W'(1);
        end else if (!pend_valid_r || out_free) begin
          // Release the previous send beat; hold this one until the next is known.
          push             = pend_valid_r;
          pend_valid_nxt   = 1'b1;
          pend_nxt.kind    = gbn_snd_pkg::KIND_SEND;
          pend_nxt.frame   = scan_frame;
          pend_nxt.attempt = slot_cnt_r[sidx];
          pend_nxt.len     = frame_len(scan_frame, fin_frame, last_len);
          pend_nxt.fin     = (scan_frame == fin_frame);
          slot_time_nxt[sidx] = ev_now_r;
          slot_sent_nxt[sidx] = 1'b1;
          if (slot_cnt_r[sidx] != '1) begin
            slot_cnt_nxt[sidx] = slot_cnt_r[sidx] + ATTEMPT_W'(1);
          end
          idx_nxt = idx_r + SCAN_W'(1);
        end
      end

      gbn_snd_pkg::ST_FLUSH: begin
        if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          if (!pend_valid_r) begin
            push_res.kind    = gbn_snd_pkg::KIND_NONE;
            push_res.frame   = '0;
            push_res.attempt = '0;
            push_res.len     = '0;
            push_res.fin     = 1'b0;
          end
          pend_valid_nxt = 1'b0;
          state_nxt      = gbn_snd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = gbn_snd_pkg::ST_IDLE;
      end
    endcase

    // Output register: load on push, drop once taken.
    out_res_nxt   = out_res_r;
    out_last_nxt  = out_last_r;
    out_all_nxt   = out_all_r;
    out_rtt_nxt   = out_rtt_r;
    out_valid_nxt = out_valid_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = push_res;
      out_last_nxt  = push_last;
      out_all_nxt   = final_acked_r;
      out_rtt_nxt   = rtt_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // Register writes; initial rtt also reloads the estimate.
    if (cfg_valid) begin
      case (cfg_index)
        gbn_snd_pkg::CFG_WINDOW_SIZE: wsize_nxt = cfg_data[gbn_snd_pkg::WSIZE_W-1:0];
        gbn_snd_pkg::CFG_INITIAL_RTT: begin
          init_rtt_nxt = cfg_data[RTT_W-1:0];
          rtt_nxt      = cfg_data[RTT_W-1:0];
        end
        gbn_snd_pkg::CFG_TOTAL_BYTES: total_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= gbn_snd_pkg::ST_IDLE;
      wsize_r       <= gbn_snd_pkg::WSIZE_W'(15);
      init_rtt_r    <= RTT_W'(100);
      total_r       <= TOTAL_W'(1);
      nae_r         <= '0;
      rtt_r         <= RTT_W'(100);
      final_acked_r <= 1'b0;
      slot_sent_r   <= '0;
      pend_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
      idx_r         <= '0;
      div_cnt_r     <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_time_r[i] <= '0;
        slot_cnt_r[i]  <= '0;
      end
    end else begin
      state_r       <= state_nxt;
      wsize_r       <= wsize_nxt;
      init_rtt_r    <= init_rtt_nxt;
      total_r       <= total_nxt;
      nae_r         <= nae_nxt;
      rtt_r         <= rtt_nxt;
      final_acked_r <= final_acked_nxt;
      slot_sent_r   <= slot_sent_nxt;
      pend_valid_r  <= pend_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      idx_r         <= idx_nxt;
      div_cnt_r     <= div_cnt_nxt;
      slot_time_r   <= slot_time_nxt;
      slot_cnt_r    <= slot_cnt_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ev_func_r  <= ev_func_nxt;
    ev_frame_r <= ev_frame_nxt;
    ev_att_r   <= ev_att_nxt;
    ev_now_r   <= ev_now_nxt;
    pend_r     <= pend_nxt;
    div_q_r    <= div_q_nxt;
    div_rem_r  <= div_rem_nxt;
    out_res_r  <= out_res_nxt;
    out_last_r <= out_last_nxt;
    out_all_r  <= out_all_nxt;
    out_rtt_r  <= out_rtt_nxt;
  end

  assign in_tready  = (state_r == gbn_snd_pkg::ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {6'b0, out_rtt_r, out_all_r, out_res_r.fin, out_res_r.len,
                       out_res_r.attempt, out_res_r.frame};

  // The latched function code selects the path only through the state taken.
  a_func_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gbn_snd_pkg::ST_SCAN) |-> (ev_func_r == gbn_snd_pkg::FUNC_SCAN))
    else $error("scan running for an ack event");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second event taken while one is in progress");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gbn_snd_pkg::ST_SCAN) |-> (idx_r <= ws_eff))
    else $error("scan index past window size");

  a_div_has_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gbn_snd_pkg::ST_DIV) |->
      (pend_valid_r && pend_r.kind == gbn_snd_pkg::KIND_ACK_OK))
    else $error("rtt refresh without accepted ack");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(final_acked_r))
    else $error("completion flag cleared");

endmodule
